FILE: design/mef_pkg.sv
// Shared types and constants of the morphological edge filter.
package mef_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 4;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int RAD_W      = 3;
    localparam int REG_W      = 11;
    localparam int ROW_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SIZE   = 9;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [RAD_W-1:0] RST_RADIUS = 3'd1;
    localparam logic [REG_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [REG_W-1:0] RST_HEIGHT = 11'd480;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    // per-request classification made by the front end
    typedef struct packed {
        logic s_act;   // request carries a sum position inside the frame
        logic s_int;   // that sum position is interior
        logic o_act;   // request yields an output pixel
        logic o_int;   // that output pixel is interior
        logic last;    // final output pixel of the frame
    } mef_flags_t;

endpackage

FILE: design/mef_fifo.sv
// Small request queue between the front end and the window datapath.
module mef_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         full,
    output logic         empty
);
    import mef_pkg::*;

    logic [W-1:0]       data_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/mef_front.sv
// Front end: config registers, raster counters and request classification.
module mef_front #(
    parameter int MAX_WIDTH  = mef_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = mef_pkg::DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = mef_pkg::DEF_PIXEL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mef_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mef_pkg::REG_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [PIXEL_BITS-1:0]             pixel,
    input  logic                              is_flush,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [PIXEL_BITS-1:0]             q_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]      q_col,
    output logic [$clog2(MAX_WIDTH)-1:0]      q_scol,
    output mef_pkg::mef_flags_t               q_flags,
    output logic [mef_pkg::RAD_W-1:0]         radius
);
    import mef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > REG_W) ? CW + 1 : REG_W;

    logic [RAD_W-1:0] radius_reg;
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;

    logic [CW-1:0]    in_col_reg,  in_col_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic             s_run_reg,   s_run_next;
    logic [CW-1:0]    s_col_reg,   s_col_next;
    logic [ROW_W-1:0] s_row_reg,   s_row_next;
    logic             o_run_reg,   o_run_next;
    logic [CW-1:0]    o_col_reg,   o_col_next;
    logic [ROW_W-1:0] o_row_reg,   o_row_next;

    logic [RAD_W-1:0] r_eff;
    logic [EW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [EW-1:0]    r_w;
    logic [ROW_W-1:0] r_h;
    logic             accept;
    logic             cfg_hit;
    logic             s_cur;
    logic             o_cur;
    logic [CW-1:0]    s_col_cur, o_col_cur;
    logic [ROW_W-1:0] s_row_cur, o_row_cur;
    logic             last;

    function automatic logic interior(input logic [ROW_W-1:0] row, input logic [CW-1:0] col,
                                      input logic [ROW_W-1:0] rh, input logic [EW-1:0] rw,
                                      input logic [ROW_W-1:0] h, input logic [EW-1:0] w);
        return (row >= rh) && (row < h - rh) && (EW'(col) >= rw) && (EW'(col) < w - rw);
    endfunction

    function automatic logic wraps(input logic [CW-1:0] col, input logic [EW-1:0] w);
        return (EW'(col) + EW'(1) >= w);
    endfunction

    always_comb
    begin
        r_eff = radius_reg;
        if (radius_reg == '0)
        begin
            r_eff = RAD_W'(1);
        end
        else if (radius_reg > RAD_W'(MAX_RADIUS))
        begin
            r_eff = RAD_W'(MAX_RADIUS);
        end
        w_eff = EW'(width_reg);
        if (EW'(width_reg) < EW'(MIN_SIZE))
        begin
            w_eff = EW'(MIN_SIZE);
        end
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg < ROW_W'(MIN_SIZE))
        begin
            h_eff = ROW_W'(MIN_SIZE);
        end
        else if (height_reg > ROW_W'(MAX_HEIGHT))
        begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end
    end

    assign r_w    = EW'(r_eff);
    assign r_h    = ROW_W'(r_eff);
    assign radius = r_eff;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cfg_hit  = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH
                                 || cfg_index == REG_HEIGHT);

    // sum stage trails input by R*W+R, output trails the sum stage by the same
    always_comb
    begin
        s_cur     = s_run_reg || (in_row_reg == r_h && EW'(in_col_reg) == r_w);
        s_col_cur = s_run_reg ? s_col_reg : '0;
        s_row_cur = s_run_reg ? s_row_reg : '0;
        o_cur     = o_run_reg || (s_cur && s_row_cur == r_h && EW'(s_col_cur) == r_w);
        o_col_cur = o_run_reg ? o_col_reg : '0;
        o_row_cur = o_run_reg ? o_row_reg : '0;
        last      = o_cur && (o_row_cur == h_eff - ROW_W'(1))
                    && (EW'(o_col_cur) == w_eff - EW'(1));

        q_flags.s_act = s_cur && (s_row_cur < h_eff);
        q_flags.s_int = interior(s_row_cur, s_col_cur, r_h, r_w, h_eff, w_eff);
        q_flags.o_act = o_cur;
        q_flags.o_int = interior(o_row_cur, o_col_cur, r_h, r_w, h_eff, w_eff);
        q_flags.last  = last;

        q_push = accept;
        q_pix  = (is_flush || in_row_reg >= h_eff) ? '0 : pixel;
        q_col  = in_col_reg;
        q_scol = s_col_cur;
    end

    always_comb
    begin
        in_col_next = wraps(in_col_reg, w_eff) ? '0 : in_col_reg + 1'b1;
        in_row_next = wraps(in_col_reg, w_eff) ? in_row_reg + 1'b1 : in_row_reg;
        s_run_next  = s_cur;
        s_col_next  = s_col_reg;
        s_row_next  = s_row_reg;
        o_run_next  = o_cur;
        o_col_next  = o_col_reg;
        o_row_next  = o_row_reg;
        if (s_cur)
        begin
            s_col_next = wraps(s_col_cur, w_eff) ? '0 : s_col_cur + 1'b1;
            s_row_next = wraps(s_col_cur, w_eff) ? s_row_cur + 1'b1 : s_row_cur;
        end
        if (o_cur)
        begin
            o_col_next = wraps(o_col_cur, w_eff) ? '0 : o_col_cur + 1'b1;
            o_row_next = wraps(o_col_cur, w_eff) ? o_row_cur + 1'b1 : o_row_cur;
        end
        if (last)
        begin
            in_col_next = '0;
            in_row_next = '0;
            s_run_next  = 1'b0;
            o_run_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RST_RADIUS;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            in_col_reg <= '0;
            in_row_reg <= '0;
            s_run_reg  <= 1'b0;
            s_col_reg  <= '0;
            s_row_reg  <= '0;
            o_run_reg  <= 1'b0;
            o_col_reg  <= '0;
            o_row_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default:    radius_reg <= radius_reg;
            endcase
            in_col_reg <= '0;
            in_row_reg <= '0;
            s_run_reg  <= 1'b0;
            o_run_reg  <= 1'b0;
        end
        else if (accept)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            s_run_reg  <= s_run_next;
            s_col_reg  <= s_col_next;
            s_row_reg  <= s_row_next;
            o_run_reg  <= o_run_next;
            o_col_reg  <= o_col_next;
            o_row_reg  <= o_row_next;
        end
    end

endmodule

FILE: design/mef_back.sv
// Back end: line stores, window sum stage and window min/max gradient stage.
module mef_back #(
    parameter int MAX_WIDTH  = mef_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = mef_pkg::DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = mef_pkg::DEF_PIXEL_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mef_pkg::RAD_W-1:0]      radius,
    input  logic                           q_empty,
    input  logic [PIXEL_BITS-1:0]          q_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]   q_col,
    input  logic [$clog2(MAX_WIDTH)-1:0]   q_scol,
    input  mef_pkg::mef_flags_t            q_flags,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [PIXEL_BITS-1:0]          edge_value,
    output logic                           last_of_frame
);
    import mef_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int T     = 2 * MAX_RADIUS + 1;
    localparam int NL    = 2 * MAX_RADIUS;
    localparam int COL_W = PIXEL_BITS + $clog2(T);
    localparam int SUM_W = PIXEL_BITS + $clog2(T * T);
    localparam int TOT_W = COL_W + $clog2(T);
    localparam logic [SUM_W-1:0] FULL = SUM_W'((1 << PIXEL_BITS) - 1);

    logic en;
    logic s0_v;

    // line stores: bank k holds the row k+1 above the newest one
    logic [PIXEL_BITS-1:0] pix_mem [NL][MAX_WIDTH];
    logic [PIXEL_BITS-1:0] prd_reg [NL];
    logic [SUM_W-1:0]      sum_mem [NL][MAX_WIDTH];
    logic [SUM_W-1:0]      srd_reg [NL];

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    mef_flags_t            f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg, f7_reg, f8_reg;
    logic [CW-1:0]         col1_reg;
    logic [CW-1:0]         scol1_reg, scol2_reg, scol3_reg, scol4_reg, scol5_reg;
    logic [PIXEL_BITS-1:0] pix1_reg;
    logic [COL_W-1:0]      csum2_reg;
    logic [PIXEL_BITS-1:0] cpix2_reg;
    logic [COL_W-1:0]      hs_reg [T];
    logic [PIXEL_BITS-1:0] hc_reg [T];
    logic [SUM_W-1:0]      sum4_reg, sum5_reg;
    logic [SUM_W-1:0]      cmin6_reg, cmax6_reg, cctr6_reg;
    logic [SUM_W-1:0]      hmn_reg [T];
    logic [SUM_W-1:0]      hmx_reg [T];
    logic [SUM_W-1:0]      hct_reg [T];
    logic [SUM_W-1:0]      lo8_reg, hi8_reg, ctr8_reg;
    logic                  ov_reg;
    logic [PIXEL_BITS-1:0] edge_reg;
    logic                  last_reg;

    logic [PIXEL_BITS-1:0] ptap [T];
    logic [SUM_W-1:0]      utap [T];
    logic [COL_W-1:0]      csum;
    logic [PIXEL_BITS-1:0] cpix;
    logic [TOT_W-1:0]      wsum;
    logic [PIXEL_BITS-1:0] wctr;
    logic [SUM_W-1:0]      sum3;
    logic [SUM_W-1:0]      cmin, cmax, cctr;
    logic [SUM_W-1:0]      wlo, whi, wctr2;
    logic [SUM_W-1:0]      d1, d2, dmin;
    logic [PIXEL_BITS-1:0] edge_calc;

    assign en    = !ov_reg || out_ready;
    assign s0_v  = !q_empty;
    assign q_pop = en && s0_v;

    // pixel line stores
    always_ff @(posedge clk)
    begin
        if (en && s0_v)
        begin
            for (int k = 0; k < NL; k++)
            begin
                prd_reg[k] <= pix_mem[k][q_col];
            end
            pix_mem[0][q_col] <= q_pix;
        end
        if (en && v1_reg)
        begin
            for (int k = 1; k < NL; k++)
            begin
                pix_mem[k][col1_reg] <= prd_reg[k-1];
            end
        end
    end

    // column sum over rows y-2R..y, plus the pixel of row y-R
    always_comb
    begin
        ptap[0] = pix1_reg;
        for (int k = 0; k < NL; k++)
        begin
            ptap[k+1] = prd_reg[k];
        end
        csum = '0;
        cpix = '0;
        for (int j = 0; j < T; j++)
        begin
            if (j <= 2 * int'(radius))
            begin
                csum = csum + COL_W'(ptap[j]);
            end
            if (j == int'(radius))
            begin
                cpix = ptap[j];
            end
        end
    end

    // window sum minus centre
    always_comb
    begin
        wsum = '0;
        wctr = '0;
        for (int j = 0; j < T; j++)
        begin
            if (j <= 2 * int'(radius))
            begin
                wsum = wsum + TOT_W'(hs_reg[j]);
            end
            if (j == int'(radius))
            begin
                wctr = hc_reg[j];
            end
        end
        sum3 = SUM_W'(wsum - TOT_W'(wctr));
    end

    // sum line stores
    always_ff @(posedge clk)
    begin
        if (en && v4_reg && f4_reg.s_act)
        begin
            for (int k = 0; k < NL; k++)
            begin
                srd_reg[k] <= sum_mem[k][scol4_reg];
            end
            sum_mem[0][scol4_reg] <= sum4_reg;
        end
        if (en && v5_reg && f5_reg.s_act)
        begin
            for (int k = 1; k < NL; k++)
            begin
                sum_mem[k][scol5_reg] <= srd_reg[k-1];
            end
        end
    end

    // column min/max of sums
    always_comb
    begin
        utap[0] = sum5_reg;
        for (int k = 0; k < NL; k++)
        begin
            utap[k+1] = srd_reg[k];
        end
        cmin = '1;
        cmax = '0;
        cctr = '0;
        for (int j = 0; j < T; j++)
        begin
            if (j <= 2 * int'(radius))
            begin
                if (utap[j] < cmin)
                begin
                    cmin = utap[j];
                end
                if (utap[j] > cmax)
                begin
                    cmax = utap[j];
                end
            end
            if (j == int'(radius))
            begin
                cctr = utap[j];
            end
        end
    end

    // window min/max of sums
    always_comb
    begin
        wlo   = '1;
        whi   = '0;
        wctr2 = '0;
        for (int j = 0; j < T; j++)
        begin
            if (j <= 2 * int'(radius))
            begin
                if (hmn_reg[j] < wlo)
                begin
                    wlo = hmn_reg[j];
                end
                if (hmx_reg[j] > whi)
                begin
                    whi = hmx_reg[j];
                end
            end
            if (j == int'(radius))
            begin
                wctr2 = hct_reg[j];
            end
        end
    end

    always_comb
    begin
        d1   = (ctr8_reg >= lo8_reg) ? ctr8_reg - lo8_reg : '0;
        d2   = (hi8_reg >= ctr8_reg) ? hi8_reg - ctr8_reg : '0;
        dmin = (d1 < d2) ? d1 : d2;
        edge_calc = (dmin > FULL) ? FULL[PIXEL_BITS-1:0] : dmin[PIXEL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s0_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            ov_reg <= v8_reg && f8_reg.o_act;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg    <= q_flags;
            col1_reg  <= q_col;
            scol1_reg <= q_scol;
            pix1_reg  <= q_pix;

            f2_reg    <= f1_reg;
            scol2_reg <= scol1_reg;
            csum2_reg <= csum;
            cpix2_reg <= cpix;

            f3_reg    <= f2_reg;
            scol3_reg <= scol2_reg;

            f4_reg    <= f3_reg;
            scol4_reg <= scol3_reg;
            sum4_reg  <= f3_reg.s_int ? sum3 : '0;

            f5_reg    <= f4_reg;
            scol5_reg <= scol4_reg;
            sum5_reg  <= sum4_reg;

            f6_reg    <= f5_reg;
            cmin6_reg <= cmin;
            cmax6_reg <= cmax;
            cctr6_reg <= cctr;

            f7_reg    <= f6_reg;

            f8_reg    <= f7_reg;
            lo8_reg   <= wlo;
            hi8_reg   <= whi;
            ctr8_reg  <= wctr2;

            edge_reg  <= f8_reg.o_int ? edge_calc : '0;
            last_reg  <= f8_reg.last;

            if (v2_reg)
            begin
                hs_reg[0] <= csum2_reg;
                hc_reg[0] <= cpix2_reg;
                for (int j = 1; j < T; j++)
                begin
                    hs_reg[j] <= hs_reg[j-1];
                    hc_reg[j] <= hc_reg[j-1];
                end
            end
            if (v6_reg && f6_reg.s_act)
            begin
                hmn_reg[0] <= cmin6_reg;
                hmx_reg[0] <= cmax6_reg;
                hct_reg[0] <= cctr6_reg;
                for (int j = 1; j < T; j++)
                begin
                    hmn_reg[j] <= hmn_reg[j-1];
                    hmx_reg[j] <= hmx_reg[j-1];
                    hct_reg[j] <= hct_reg[j-1];
                end
            end
        end
    end

    assign out_valid     = ov_reg;
    assign edge_value    = edge_reg;
    assign last_of_frame = last_reg;

endmodule

FILE: design/morphological_edge_filter.sv
// Morphological gradient edge filter for one image plane in raster order. One pixel is
// taken per clock and one result given per clock once the pipeline is primed and while
// m_axis_tready allows: item t of a frame yields output pixel t - 2*(R*W+R), so a frame
// of W*H pixels needs 2*(R*W+R) flush requests after its last pixel to drain. On top of
// that, m_axis_tvalid rises after the request passes the queue plus eight line-store and
// window stages. Line stores are 2*MAX_RADIUS banks of MAX_WIDTH entries for pixels and
// for window sums, each read and written at most once per clock; there is no clearing
// pass after reset. Border pixels of the output are zero. A configuration write restarts
// the frame and must only be issued while the block is idle.
module morphological_edge_filter #(
    parameter int MAX_WIDTH  = mef_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = mef_pkg::DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = mef_pkg::DEF_PIXEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mef_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mef_pkg::REG_W-1:0]           cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,   // pixel
    input  logic                                s_axis_tuser,   // is_flush
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,   // edge_value
    output logic                                m_axis_tlast    // last_of_frame
);
    import mef_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int FW  = $bits(mef_flags_t);
    localparam int QW  = FW + 2 * CW + PIXEL_BITS;

    logic                  q_push, q_pop, q_full, q_empty;
    logic [PIXEL_BITS-1:0] f_pix, b_pix;
    logic [CW-1:0]         f_col, f_scol, b_col, b_scol;
    mef_flags_t            f_flags, b_flags;
    logic [QW-1:0]         q_head;
    logic [RAD_W-1:0]      radius;
    logic [PIXEL_BITS-1:0] edge_value;

    mef_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel     (s_axis_tdata[PIXEL_BITS-1:0]),
        .is_flush  (s_axis_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_pix     (f_pix),
        .q_col     (f_col),
        .q_scol    (f_scol),
        .q_flags   (f_flags),
        .radius    (radius)
    );

    mef_fifo #(
        .W (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_flags, f_scol, f_col, f_pix}),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_flags, b_scol, b_col, b_pix} = q_head;

    mef_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius        (radius),
        .q_empty       (q_empty),
        .q_pix         (b_pix),
        .q_col         (b_col),
        .q_scol        (b_scol),
        .q_flags       (b_flags),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .edge_value    (edge_value),
        .last_of_frame (m_axis_tlast)
    );

    assign m_axis_tdata = TDW'(edge_value);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("request queue overflow");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("queue full and empty at once");

    a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
        else $error("last pixel of frame is a border pixel and must be zero");
`endif

endmodule

FILE: tb/morphological_edge_filter_tb.sv
// Self-checking testbench for the morphological edge filter: random frames, stalls, checker.
`timescale 1ns / 100ps

module morphological_edge_filter_tb;
    import mef_pkg::*;

    localparam int RING = 10;
    localparam int MAXW = 1024;
    localparam int FULL = 255;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic [7:0] pixel;
        logic       flush;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] edge_val;
        logic       last;
    } edge_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_RADIUS;
    logic [REG_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // pixel
    logic s_axis_tuser = 1'b0;       // is_flush
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // edge_value
    logic m_axis_tlast;              // last_of_frame

    morphological_edge_filter dut (.*);

    initial forever #2 clk = ~clk;

    pix_req_t  pending_pixels[$];
    edge_res_t expected_edges[$];

    // predictor state
    int unsigned reg_radius, reg_width, reg_height;
    int unsigned pix_ring[RING*MAXW];
    int unsigned sum_ring[RING*MAXW];
    int unsigned in_col, in_row;

    int errors = 0;
    int n_results = 0;
    int n_frames = 0;
    int n_items = 0;
    int cycles = 0;
    bit hold = 0;
    bit in_acc = 0, out_acc = 0;
    int in_gap = 0, out_stall = 0;
    int gap_max = 9, stall_max = 9;

    function automatic int unsigned eff_r();
        return reg_radius < 1 ? 1 : (reg_radius > 4 ? 4 : reg_radius);
    endfunction
    function automatic int unsigned eff_w();
        return reg_width < 9 ? 9 : (reg_width > MAXW ? MAXW : reg_width);
    endfunction
    function automatic int unsigned eff_h();
        return reg_height < 9 ? 9 : (reg_height > 1024 ? 1024 : reg_height);
    endfunction
    function automatic int unsigned slot(int unsigned row, int unsigned col);
        return (row % RING) * MAXW + col;
    endfunction

    task automatic predict_edge(input pix_req_t req);
        int unsigned r, w, h, total, lag, t, ts, rs, cs, to, ro, co, sum, side;
        int unsigned lo, hi, centre, s, d1, d2, e;
        edge_res_t res;
        bit done;
        r = eff_r(); w = eff_w(); h = eff_h();
        total = w * h; lag = r * w + r;
        t = in_row * w + in_col;
        done = 0;
        if (t < total)
            pix_ring[slot(in_row, in_col)] = req.flush ? 0 : req.pixel;
        if (t >= lag && t - lag < total) begin
            ts = t - lag; rs = ts / w; cs = ts % w; sum = 0;
            if (rs >= r && rs < h - r && cs >= r && cs < w - r)
                for (int dy = 0; dy <= 2 * r; dy++)
                    for (int dx = 0; dx <= 2 * r; dx++)
                        if (dy != r || dx != r)
                            sum += pix_ring[slot(rs - r + dy, cs - r + dx)];
            sum_ring[slot(rs, cs)] = sum;
        end
        if (t >= 2 * lag && t - 2 * lag < total) begin
            to = t - 2 * lag; ro = to / w; co = to % w; e = 0;
            if (ro >= r && ro < h - r && co >= r && co < w - r) begin
                side = 2 * r + 1;
                lo = (side * side - 1) * FULL; hi = 0;
                centre = sum_ring[slot(ro, co)];
                for (int dy = 0; dy < side; dy++)
                    for (int dx = 0; dx < side; dx++) begin
                        s = sum_ring[slot(ro - r + dy, co - r + dx)];
                        if (s > hi) hi = s;
                        if (s < lo) lo = s;
                    end
                d1 = centre >= lo ? centre - lo : 0;
                d2 = hi >= centre ? hi - centre : 0;
                e = d1 < d2 ? d1 : d2;
                if (e > FULL) e = FULL;
            end
            res.edge_val = e[7:0];
            res.last = (to == total - 1);
            expected_edges.push_back(res);
            done = res.last;
        end
        if (done) begin
            in_col = 0; in_row = 0;
        end else begin
            in_col++;
            if (in_col >= w) begin
                in_col = 0; in_row++;
            end
        end
    endtask

    // sampling at the rising edge
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("[morphological_edge_filter] ERROR");
            $finish;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_edge('{s_axis_tdata, s_axis_tuser});
            in_acc = 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            out_acc = 1;
            n_results++;
            if (expected_edges.size() == 0) begin
                errors++;
                $display("%0t unexpected result: actual edge=%0d last=%0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                edge_res_t x;
                x = expected_edges.pop_front();
                if (x.edge_val !== m_axis_tdata || x.last !== m_axis_tlast) begin
                    errors++;
                    $display("%0t mismatch: expected edge=%0d last=%0b actual edge=%0d last=%0b",
                             $time, x.edge_val, x.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // request driver
    always @(negedge clk) begin
        bit taken;
        taken = in_acc;
        if (in_acc) begin
            in_acc = 0;
            in_gap = $urandom_range(0, gap_max);
        end
        if (s_axis_tvalid && !taken) begin
            // holding the current request
        end else if (!hold && pending_pixels.size() != 0 && in_gap == 0 && rst_n) begin
            pix_req_t p;
            p = pending_pixels.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= p.pixel;
            s_axis_tuser <= p.flush;
        end else begin
            s_axis_tvalid <= 1'b0;
            if (in_gap > 0) in_gap--;
        end
    end

    // result sink with random backpressure
    always @(negedge clk) begin
        if (out_acc) begin
            out_acc = 0;
            out_stall = $urandom_range(0, stall_max);
        end
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[REG_W-1:0];
        case (idx)
            REG_RADIUS: reg_radius = val & 7;
            REG_WIDTH:  reg_width = val & 11'h7FF;
            default:    reg_height = val & 11'h7FF;
        endcase
        in_col = 0; in_row = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(input int unsigned r, input int unsigned w, input int unsigned h);
        write_reg(REG_RADIUS, r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic drain_all();
        wait (pending_pixels.size() == 0);
        @(posedge clk);
        wait (!s_axis_tvalid);
        wait (expected_edges.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // one frame plus its drain; mode picks the pixel content
    task automatic push_frame(input int mode, input int flush_pct);
        int unsigned w, h, lag;
        pix_req_t p;
        w = eff_w(); h = eff_h(); lag = eff_r() * w + eff_r();
        for (int i = 0; i < w * h; i++) begin
            case (mode)
                0: p.pixel = 8'($urandom);
                1: p.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2: p.pixel = 8'hFF;
                3: p.pixel = 8'((i % w) * 13 + (i / w) * 7);
                default: p.pixel = 8'($urandom_range(100, 110));
            endcase
            p.flush = ($urandom_range(0, 99) < flush_pct);
            pending_pixels.push_back(p);
            n_items++;
        end
        // drain ticks: pixel values here are lost either way
        for (int i = 0; i < 2 * lag; i++) begin
            p.pixel = 8'($urandom);
            p.flush = 1'($urandom_range(0, 1));
            pending_pixels.push_back(p);
            n_items++;
        end
        n_frames++;
    endtask

    initial begin
        reg_radius = 1; reg_width = 640; reg_height = 480;
        in_col = 0; in_row = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: smallest frame, saturated and binary content, in-frame flushes
        setup(1, 9, 9);
        push_frame(2, 20);
        wait (pending_pixels.size() < 60);
        hold = 1;
        @(posedge clk);
        wait (expected_edges.size() == 0 && !s_axis_tvalid);
        hold = 0;
        drain_all();
        setup(4, 9, 9);
        push_frame(1, 0);
        drain_all();
        // out-of-range values clamp: radius 7 to 4 and 0 to 1, sizes to 9x9
        setup(7, 3, 5);
        push_frame(0, 5);
        drain_all();
        setup(0, 0, 0);
        push_frame(3, 0);
        drain_all();
        // wider rows, then taller columns with no idling on either side
        setup(1, 40, 9);
        push_frame(0, 2);
        drain_all();
        gap_max = 0; stall_max = 0;
        setup(4, 9, 20);
        push_frame(4, 2);
        drain_all();
        gap_max = 9; stall_max = 9;

        // random frames
        while (n_items < 1550) begin
            if ($urandom_range(0, 9) == 0)
                setup($urandom_range(0, 7), $urandom_range(0, 12), $urandom_range(0, 12));
            else
                setup($urandom_range(1, 4), $urandom_range(9, 20), $urandom_range(9, 14));
            gap_max = $urandom_range(0, 3) == 0 ? 0 : 9;
            stall_max = $urandom_range(0, 3) == 0 ? 0 : 9;
            push_frame($urandom_range(0, 4), $urandom_range(0, 1) ? 0 : 5);
            drain_all();
        end
        drain_all();

        $display("Covered %0d frames, %0d requests, %0d results checked;", n_frames, n_items,
                 n_results);
        $display("radius 1..4, clamped and in-range sizes, idle gaps, backpressure, a full pause.");
        if (errors == 0)
            $display("[morphological_edge_filter] OK");
        else
            $display("[morphological_edge_filter] ERROR");
        $finish;
    end
endmodule
